// ===== design/lrwd_pkg.sv =====
// ----------------------------------------------------------------------------
// LZSS ring window decoder package
// Shared constants, the sequencer state type and the beat type that passes
// decoded bytes from the sequencer to the result stage.
// ----------------------------------------------------------------------------
`default_nettype none

package lrwd_pkg;

   localparam int unsigned WinSize   = 4096;
   localparam int unsigned AddrW     = 12;
   localparam int unsigned ByteW     = 8;
   localparam int unsigned CountW    = 32;
   localparam int unsigned LenW      = 5;
   localparam int unsigned MaxMatch  = 18;
   localparam int unsigned MatchBias = 3;

   localparam logic [AddrW-1:0]  WpReset   = AddrW'(WinSize - MaxMatch);
   localparam logic [AddrW-1:0]  ClrLast   = AddrW'(WinSize - 1);
   localparam logic [ByteW-1:0]  FillByte  = 8'hFF;
   localparam logic [3:0]        FlagCount = 4'd8;
   localparam logic [CountW-1:0] CountMax  = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LIT,
      ST_MATCH
   } state_type;

   typedef struct packed {
      logic             valid;
      logic [ByteW-1:0] data;
      logic             last;
   } emit_type;

endpackage

`default_nettype wire

// ===== design/lrwd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single port write, single port read RAM
// One write and one read per cycle; the read data is registered and returns
// the contents from before a write to the same address in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lrwd_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output      logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/lrwd_seq.sv =====
// ----------------------------------------------------------------------------
// LZSS ring window decoder sequencer
// Parses flag, literal and match bytes, sweeps the window with fill bytes,
// and runs match copies as a read, emit and write-back loop on the window.
// ----------------------------------------------------------------------------
`default_nettype none

module lrwd_seq (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_ready,
   input  wire logic [lrwd_pkg::ByteW-1:0]  req_in_byte,
   input  wire logic                        req_start_of_stream,
   input  wire logic                        req_end_of_stream,
   input  wire logic                        out_free,
   output      lrwd_pkg::emit_type          emit,
   output      logic                        ram_wr_en,
   output      logic [lrwd_pkg::AddrW-1:0]  ram_wr_addr,
   output      logic [lrwd_pkg::ByteW-1:0]  ram_wr_data,
   output      logic [lrwd_pkg::AddrW-1:0]  ram_rd_addr,
   input  wire logic [lrwd_pkg::ByteW-1:0]  ram_rd_data
);

   import lrwd_pkg::*;

   state_type        state_ff, state_in;
   logic [AddrW-1:0] clr_ff, clr_in;
   logic [AddrW-1:0] wp_ff, wp_in;
   logic [AddrW-1:0] rp_ff, rp_in;
   logic [LenW-1:0]  len_ff, len_in;
   logic [ByteW-1:0] flag_bits_ff, flag_bits_in;
   logic [3:0]       flags_left_ff, flags_left_in;
   logic             awaiting_ff, awaiting_in;
   logic [ByteW-1:0] low_ff, low_in;
   logic [ByteW-1:0] lit_ff, lit_in;
   logic             fwd_ff, fwd_in;
   logic [ByteW-1:0] fwd_data_ff, fwd_data_in;

   logic             accept;
   logic             is_flag;
   logic             is_second;
   logic             is_lit;
   logic [AddrW-1:0] match_pos;
   logic [LenW-1:0]  match_len;
   logic [ByteW-1:0] byte_now;

   assign accept    = req_valid && req_ready;
   assign is_flag   = (flags_left_ff == 4'd0);
   assign is_second = !is_flag && awaiting_ff;
   assign is_lit    = !is_flag && !awaiting_ff && flag_bits_ff[0];
   assign match_pos = {req_in_byte[7:4], low_ff};
   assign match_len = {1'b0, req_in_byte[3:0]} + LenW'(MatchBias);
   assign byte_now  = fwd_ff ? fwd_data_ff : ram_rd_data;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == ClrLast) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_start_of_stream) begin
                  state_in = ST_CLEAR;
               end else if (is_second) begin
                  state_in = ST_MATCH;
               end else if (is_lit) begin
                  state_in = ST_LIT;
               end
            end
         end
         ST_LIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_MATCH: begin
            if (out_free && (len_ff == LenW'(1))) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = wp_ff;
      ram_wr_data = byte_now;
      ram_rd_addr = rp_ff;
      emit        = '0;
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = FillByte;
         end
         ST_IDLE: begin
            req_ready   = 1'b1;
            ram_rd_addr = match_pos;
         end
         ST_LIT: begin
            ram_wr_data = lit_ff;
            if (out_free) begin
               ram_wr_en  = 1'b1;
               emit.valid = 1'b1;
               emit.data  = lit_ff;
               emit.last  = 1'b1;
            end
         end
         ST_MATCH: begin
            if (out_free) begin
               ram_wr_en   = 1'b1;
               ram_rd_addr = rp_ff + AddrW'(1);
               emit.valid  = 1'b1;
               emit.data   = byte_now;
               emit.last   = (len_ff == LenW'(1));
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      clr_in        = (state_ff == ST_CLEAR) ? clr_ff + AddrW'(1) : '0;
      wp_in         = wp_ff;
      rp_in         = rp_ff;
      len_in        = len_ff;
      flag_bits_in  = flag_bits_ff;
      flags_left_in = flags_left_ff;
      awaiting_in   = awaiting_ff;
      low_in        = low_ff;
      lit_in        = lit_ff;
      fwd_in        = ram_wr_en && (ram_wr_addr == ram_rd_addr);
      fwd_data_in   = ram_wr_data;

      if (accept) begin
         if (req_start_of_stream) begin
            wp_in         = WpReset;
            low_in        = '0;
            awaiting_in   = 1'b0;
            flag_bits_in  = req_in_byte;
            flags_left_in = FlagCount;
         end else if (is_flag) begin
            flag_bits_in  = req_in_byte;
            flags_left_in = FlagCount;
         end else if (is_second) begin
            rp_in         = match_pos;
            len_in        = match_len;
            awaiting_in   = 1'b0;
            flag_bits_in  = flag_bits_ff >> 1;
            flags_left_in = flags_left_ff - 4'd1;
         end else if (is_lit) begin
            lit_in        = req_in_byte;
            flag_bits_in  = flag_bits_ff >> 1;
            flags_left_in = flags_left_ff - 4'd1;
         end else begin
            low_in        = req_in_byte;
            awaiting_in   = 1'b1;
         end
         if (req_end_of_stream) begin
            flags_left_in = 4'd0;
            awaiting_in   = 1'b0;
         end
      end

      if (emit.valid) begin
         wp_in = wp_ff + AddrW'(1);
         if (state_ff == ST_MATCH) begin
            rp_in  = rp_ff + AddrW'(1);
            len_in = len_ff - LenW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         wp_ff         <= WpReset;
         flag_bits_ff  <= '0;
         flags_left_ff <= '0;
         awaiting_ff   <= 1'b0;
         low_ff        <= '0;
         fwd_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         wp_ff         <= wp_in;
         flag_bits_ff  <= flag_bits_in;
         flags_left_ff <= flags_left_in;
         awaiting_ff   <= awaiting_in;
         low_ff        <= low_in;
         fwd_ff        <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      rp_ff       <= rp_in;
      len_ff      <= len_in;
      lit_ff      <= lit_in;
      fwd_data_ff <= fwd_data_in;
   end

endmodule

`default_nettype wire

// ===== design/lzss_ring_window_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// LZSS ring window decoder unit
// Expands a stream of compressed bytes through a 4096-byte ring window.
//
// The req channel takes one compressed byte per beat together with start and
// end of stream marks. The rsp channel returns one decompressed byte per beat
// with a last-of-run mark and the saturating byte count of the stream.
// A flag byte or a first match byte yields no beat. A literal is registered
// in the sequencer and then in the output register before it appears on rsp.
// The window read for each copied match byte is issued in the cycle before
// it is sent and the byte is written back in the cycle it is sent, so while
// rsp is not stalled one byte per cycle leaves the single window memory.
// A new req beat is taken once the previous item has sent its last byte
// into the output register. After reset, and after any beat marked start
// of stream, the window is swept with 0xFF at every address while req is
// held not ready. When rsp is stalled the output register holds its beat
// and the copy loop waits; no byte is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module lzss_ring_window_decoder_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire logic [lrwd_pkg::ByteW-1:0]   req_in_byte,
   input  wire logic                         req_start_of_stream,
   input  wire logic                         req_end_of_stream,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output      logic [lrwd_pkg::ByteW-1:0]   rsp_out_byte,
   output      logic                         rsp_last_of_run,
   output      logic [lrwd_pkg::CountW-1:0]  rsp_bytes_so_far
);

   import lrwd_pkg::*;

   emit_type          emit;
   logic              out_free;
   logic              ram_wr_en;
   logic [AddrW-1:0]  ram_wr_addr;
   logic [ByteW-1:0]  ram_wr_data;
   logic [AddrW-1:0]  ram_rd_addr;
   logic [ByteW-1:0]  ram_rd_data;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ByteW-1:0]  rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [CountW-1:0] rsp_count_ff, rsp_count_in;
   logic [CountW-1:0] count_ff, count_in;

   lrwd_ram #(
      .Width (ByteW),
      .Depth (WinSize)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   lrwd_seq u_seq (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_in_byte         (req_in_byte),
      .req_start_of_stream (req_start_of_stream),
      .req_end_of_stream   (req_end_of_stream),
      .out_free            (out_free),
      .emit                (emit),
      .ram_wr_en           (ram_wr_en),
      .ram_wr_addr         (ram_wr_addr),
      .ram_wr_data         (ram_wr_data),
      .ram_rd_addr         (ram_rd_addr),
      .ram_rd_data         (ram_rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_count_in = rsp_count_ff;
      if (req_valid && req_ready && req_start_of_stream) begin
         count_in = '0;
      end
      if (emit.valid) begin
         if (count_ff != CountMax) begin
            count_in = count_ff + CountW'(1);
         end
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit.data;
         rsp_last_in  = emit.last;
         rsp_count_in = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = rsp_byte_ff;
   assign rsp_last_of_run  = rsp_last_ff;
   assign rsp_bytes_so_far = rsp_count_ff;

endmodule

`default_nettype wire
